// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, suspended while reset is applied.
`define FUIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Next-cycle implication, suspended while reset is applied.
`define FUIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`endif

// ===== rtl/core/fuis_pkg.sv =====
// Package with the constants, types and helper functions of the first-unique block.
package fuis_pkg;

    localparam int HISTORY_DEPTH = 1024;
    localparam int VALUE_BITS    = 12;
    localparam int IN_BITS       = 12;
    localparam int OUT_BITS      = 12;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
    localparam int COUNT_DEPTH   = 1 << VALUE_BITS;

    typedef logic [VALUE_BITS-1:0] val_t;
    typedef logic [HIST_AW-1:0]    hidx_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [1:0]            cnt_t;

    // Saturating occurrence codes.
    localparam cnt_t CNT_NONE = 2'd0;
    localparam cnt_t CNT_ONCE = 2'd1;
    localparam cnt_t CNT_MANY = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COUNT,
        ST_SCAN_HIST,
        ST_SCAN_CNT,
        ST_SCAN_CHK,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic  we;
        hidx_t waddr;
        val_t  wdata;
        logic  re;
        hidx_t raddr;
    } hist_req_t;

    typedef struct packed {
        logic we;
        val_t waddr;
        cnt_t wdata;
        logic re;
        val_t raddr;
    } cnt_req_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] first_value;
        logic                first_valid;
        logic                overflow;
    } res_t;

    // Keep the low VALUE_BITS bits of an input word.
    function automatic val_t to_val(input logic [IN_BITS-1:0] x);
        logic [31:0] t;
        t = 32'(x);
        return t[VALUE_BITS-1:0];
    endfunction

    // Fit a stored value to the output field.
    function automatic logic [OUT_BITS-1:0] to_out(input val_t x);
        logic [31:0] t;
        t = 32'(x);
        return t[OUT_BITS-1:0];
    endfunction

endpackage

// ===== rtl/core/fuis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fuis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fuis_core.sv =====
// Sequencer and datapath: count update, first-unique tracking and forward scan.
module fuis_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [11:0]        value_in,
    output fuis_pkg::hist_req_t hist_req,
    input  fuis_pkg::val_t     hist_rd_data,
    output fuis_pkg::cnt_req_t cnt_req,
    input  fuis_pkg::cnt_t     cnt_rd_data,
    output logic               res_valid,
    input  logic               res_ready,
    output fuis_pkg::res_t     res
);

    import fuis_pkg::*;

    state_t state_reg, state_next;
    val_t   clr_cnt_reg, clr_cnt_next;
    val_t   v_reg, v_next;
    logic   ovf_reg, ovf_next;
    fill_t  fill_reg, fill_next;
    hidx_t  first_idx_reg, first_idx_next;
    val_t   first_val_reg, first_val_next;
    logic   present_reg, present_next;
    hidx_t  scan_idx_reg, scan_idx_next;

    logic   accept;
    logic   full;
    logic   hit_first;
    cnt_t   cnt_new;
    fill_t  scan_succ;
    logic   scan_more;
    logic   scan_found;
    logic   clr_last;

    assign accept     = in_valid && in_ready;
    assign full       = (fill_reg == fill_t'(HISTORY_DEPTH));
    assign hit_first  = present_reg && (first_val_reg == v_reg);
    assign cnt_new    = (cnt_rd_data == CNT_NONE) ? CNT_ONCE : CNT_MANY;
    assign scan_succ  = fill_t'(scan_idx_reg) + fill_t'(1);
    assign scan_more  = (scan_succ < fill_reg);
    assign scan_found = (cnt_rd_data == CNT_ONCE);
    assign clr_last   = (clr_cnt_reg == '1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = full ? ST_EMIT : ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                state_next = hit_first ? ST_SCAN_HIST : ST_EMIT;
            end
            ST_SCAN_HIST:
            begin
                state_next = ST_SCAN_CNT;
            end
            ST_SCAN_CNT:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (scan_found || !scan_more)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SCAN_HIST;
                end
            end
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Memory requests and handshake outputs.
    always_comb
    begin
        hist_req       = '0;
        cnt_req        = '0;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        hist_req.waddr = fill_reg[HIST_AW-1:0];
        hist_req.wdata = to_val(value_in);
        hist_req.raddr = scan_idx_reg;
        cnt_req.raddr  = to_val(value_in);
        cnt_req.waddr  = v_reg;
        cnt_req.wdata  = cnt_new;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_req.we    = 1'b1;
                cnt_req.waddr = clr_cnt_reg;
                cnt_req.wdata = CNT_NONE;
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                hist_req.we = in_valid && !full;
                cnt_req.re  = in_valid && !full;
            end
            ST_COUNT:
            begin
                cnt_req.we = 1'b1;
            end
            ST_SCAN_HIST:
            begin
                hist_req.re = 1'b1;
            end
            ST_SCAN_CNT:
            begin
                cnt_req.re    = 1'b1;
                cnt_req.raddr = hist_rd_data;
            end
            ST_SCAN_CHK:
            begin
            end
            ST_EMIT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign res.first_value = present_reg ? to_out(first_val_reg) : '0;
    assign res.first_valid = present_reg;
    assign res.overflow    = ovf_reg;

    // Datapath register updates.
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        v_next         = v_reg;
        ovf_next       = ovf_reg;
        fill_next      = fill_reg;
        first_idx_next = first_idx_reg;
        first_val_next = first_val_reg;
        present_next   = present_reg;
        scan_idx_next  = scan_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + val_t'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    v_next   = to_val(value_in);
                    ovf_next = full;
                end
            end
            ST_COUNT:
            begin
                fill_next = fill_reg + fill_t'(1);
                if (hit_first)
                begin
                    present_next  = 1'b0;
                    scan_idx_next = first_idx_reg + hidx_t'(1);
                end
                else if (!present_reg && (cnt_new == CNT_ONCE))
                begin
                    present_next   = 1'b1;
                    first_idx_next = HIST_AW'(fill_reg);
                    first_val_next = v_reg;
                end
            end
            ST_SCAN_CHK:
            begin
                if (scan_found)
                begin
                    present_next   = 1'b1;
                    first_idx_next = scan_idx_reg;
                    first_val_next = hist_rd_data;
                end
                else if (scan_more)
                begin
                    scan_idx_next = HIST_AW'(scan_succ);
                end
            end
            ST_SCAN_HIST, ST_SCAN_CNT, ST_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            fill_reg      <= '0;
            first_idx_reg <= '0;
            present_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            fill_reg      <= fill_next;
            first_idx_reg <= first_idx_next;
            present_reg   <= present_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        ovf_reg       <= ovf_next;
        first_val_reg <= first_val_next;
        scan_idx_reg  <= scan_idx_next;
    end

endmodule

// ===== rtl/core/first_unique_in_stream.sv =====
// An accepted word passes through the count state (skipped when the history is full and it
// is refused) and the emit state, and its result is then held in the output register. A
// repeat of the current first unique value adds a scan of the history entries after it,
// each through a history read, a count read and a check. Words are taken one at a time,
// as the history and the count memory each have a single read port.
// Reset: control state clears at once; a clearing pass then zeroes all 2^VALUE_BITS (4096)
// entries of the count memory, and in_ready stays low until it is finished.
module first_unique_in_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] value_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] first_value,
    output logic        first_valid,
    output logic        overflow
);

    import fuis_pkg::*;

    hist_req_t hist_req;
    cnt_req_t  cnt_req;
    val_t      hist_rd_data;
    cnt_t      cnt_rd_data;
    logic      res_valid;
    logic      res_ready;
    res_t      res;

    logic      out_valid_reg, out_valid_next;
    res_t      out_reg, out_next;

    // The history store holds every word taken in while it is not full, in arrival order.
    fuis_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_req.we),
        .waddr (hist_req.waddr),
        .wdata (hist_req.wdata),
        .re    (hist_req.re),
        .raddr (hist_req.raddr),
        .rdata (hist_rd_data)
    );

    // The count store keeps a saturating occurrence count for every possible value.
    fuis_ram #(
        .WIDTH ($bits(cnt_t)),
        .DEPTH (COUNT_DEPTH)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_req.we),
        .waddr (cnt_req.waddr),
        .wdata (cnt_req.wdata),
        .re    (cnt_req.re),
        .raddr (cnt_req.raddr),
        .rdata (cnt_rd_data)
    );

    // The sequencer walks each word through count update and, when needed, the scan.
    fuis_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value_in     (value_in),
        .hist_req     (hist_req),
        .hist_rd_data (hist_rd_data),
        .cnt_req      (cnt_req),
        .cnt_rd_data  (cnt_rd_data),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // The output register decouples the sequencer from the consumer, so a finished
    // result may wait here while the next word is already being taken in.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign first_value = out_reg.first_value;
    assign first_valid = out_reg.first_valid;
    assign overflow    = out_reg.overflow;

endmodule

// ===== rtl/core/fuis_checker.sv =====
// Port-level checker for the first-unique block, bound to the top level.
`include "assert_macros.svh"

module fuis_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [11:0] value_in,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] first_value,
    input logic        first_valid,
    input logic        overflow
);

    logic in_take;
    logic in_wait;
    logic out_stall;

    assign in_take   = in_valid && in_ready;
    assign in_wait   = in_valid && !in_ready;
    assign out_stall = out_valid && !out_ready;

    // Only one word is worked on at a time.
    `FUIS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_take, !in_ready)

    // A result with no unique value reports zero.
    `FUIS_ASSERT_IMP(a_none_is_zero, clk, rst_n, out_valid && !first_valid, first_value == 12'd0)

    // A stalled result holds its word.
    `FUIS_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall,
        out_valid && $stable(first_value) && $stable(first_valid) && $stable(overflow))

    // An accepted word never produces its result in the very next cycle's edge.
    `FUIS_ASSERT_NXT(a_no_instant_result, clk, rst_n, in_take && !out_valid, !out_valid)

    // An offered word waits with its payload unchanged until it is taken.
    `FUIS_ASSERT_NXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(value_in))

endmodule

bind first_unique_in_stream fuis_checker u_fuis_checker (.*);

// ===== bench/first_unique_in_stream_test.sv =====
// Self-checking testbench for the first-unique-value stream block.
module first_unique_in_stream_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fuis_pkg::*;

    // Predicts the result of every accepted word and checks the results in order.
    // It keeps its own copy of the history, the saturating counts and the
    // position of the earliest value that has been seen exactly once.
    class unique_tracker;
        val_t  stored [HISTORY_DEPTH];
        cnt_t  seen [COUNT_DEPTH];
        int    fill;
        int    head;
        bit    head_ok;
        res_t  awaited [$];
        int    failures;
        int    refused;
        int    scans;

        function new();
            foreach (seen[i])
            begin
                seen[i] = CNT_NONE;
            end
            fill     = 0;
            head     = 0;
            head_ok  = 1'b0;
            failures = 0;
            refused  = 0;
            scans    = 0;
        endfunction

        function void note_word(input logic [11:0] word);
            val_t v;
            res_t r;
            int   pos;
            v = word[VALUE_BITS-1:0];
            r.overflow = 1'b0;
            if (fill >= HISTORY_DEPTH)
            begin
                // The history is full: the word is refused and nothing changes.
                r.overflow = 1'b1;
                refused++;
            end
            else
            begin
                pos = fill;
                stored[pos] = v;
                fill++;
                if (seen[v] == CNT_NONE)
                    seen[v] = CNT_ONCE;
                else
                    seen[v] = CNT_MANY;
                if (head_ok && head < pos && stored[head] == v)
                begin
                    // The current first unique value has repeated, so look further on.
                    scans++;
                    head_ok = 1'b0;
                    for (int i = head + 1; i < fill; i++)
                    begin
                        if (seen[stored[i]] == CNT_ONCE)
                        begin
                            head    = i;
                            head_ok = 1'b1;
                            break;
                        end
                    end
                end
                else if (!head_ok && seen[v] == CNT_ONCE)
                begin
                    head    = pos;
                    head_ok = 1'b1;
                end
            end
            if (head_ok)
            begin
                r.first_value = stored[head];
                r.first_valid = 1'b1;
            end
            else
            begin
                r.first_value = '0;
                r.first_valid = 1'b0;
            end
            awaited = {awaited, r};
        endfunction

        function void check_result(input logic [11:0] value, input logic valid,
                                   input logic ovf);
            res_t e;
            if (awaited.size() == 0)
            begin
                $display("%0t: result with nothing awaited: value %03h valid %b overflow %b",
                         $time, value, valid, ovf);
                failures++;
                return;
            end
            e = awaited.pop_front();
            if (value !== e.first_value)
            begin
                $display("%0t: first_value expected %03h, got %03h",
                         $time, e.first_value, value);
                failures++;
            end
            if (valid !== e.first_valid)
            begin
                $display("%0t: first_valid expected %b, got %b", $time, e.first_valid, valid);
                failures++;
            end
            if (ovf !== e.overflow)
            begin
                $display("%0t: overflow expected %b, got %b", $time, e.overflow, ovf);
                failures++;
            end
        endfunction
    endclass

    localparam int WORD_TOTAL = 1450;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [11:0] value_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] first_value;
    logic        first_valid;
    logic        overflow;

    unique_tracker tracker = new();

    // Idling mode: 0 none, 1 sender idle most cycles, 2 receiver stalling most
    // cycles, 3 both idling now and then.
    int mode = 0;
    int results_seen = 0;

    first_unique_in_stream dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value_in    (value_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .first_value (first_value),
        .first_valid (first_valid),
        .overflow    (overflow)
    );

    always #4 clk = ~clk;

    function automatic bit sender_rests();
        case (mode)
            1: return $urandom_range(99) < 87;
            3: return $urandom_range(99) < 11;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_rests();
        case (mode)
            2: return $urandom_range(99) < 87;
            3: return $urandom_range(99) < 11;
            default: return 1'b0;
        endcase
    endfunction

    // Chooses the next word. Repeating the current first unique value forces
    // the block to scan its history, and repeating older values drives counts
    // to saturation, so both are favoured over fresh values.
    function automatic logic [11:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 30 && tracker.head_ok)
            return tracker.stored[tracker.head];
        else if (r < 55 && tracker.fill > 0)
            return tracker.stored[$urandom_range(tracker.fill - 1)];
        else if (r < 85)
            return 12'($urandom_range(31));
        else
            return 12'($urandom);
    endfunction

    // Offers one word, starting at a falling edge, and returns at the falling
    // edge after it has been accepted. Valid is only lowered when the sender
    // chooses to rest, so back-to-back words keep it high throughout.
    task automatic send_word(input logic [11:0] word);
        while (sender_rests())
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value_in <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_word(word);
        @(negedge clk);
    endtask

    // Results are sampled at the rising edge, where both sides of the
    // handshake are stable.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_result(first_value, first_valid, overflow);
            results_seen++;
        end
    end

    // The receiver. Once a hundred results have arrived it holds off for a
    // long stretch, so that results back up and the block keeps in_ready low
    // while the sender keeps offering words.
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 100)
            begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= !receiver_rests();
            end
        end
    end

    // Stimulus and the end of the run.
    initial
    begin
        int sent;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening. The block clears its count memory first, and the
        // handshake holds the first word back until that has finished.
        mode = 0;
        send_word(12'h000);   // the very first word becomes the first unique value
        send_word(12'hFFF);
        send_word(12'h000);   // first unique repeats, the scan moves on to FFF
        send_word(12'hAAA);
        send_word(12'h555);
        send_word(12'hFFF);   // the scan passes over the repeated zero to AAA
        send_word(12'hAAA);   // the scan moves on to 555
        send_word(12'h555);   // the scan runs off the end: no unique value left
        send_word(12'h555);   // a saturated count stays saturated, still none
        send_word(12'h123);   // a fresh value becomes first unique again
        send_word(12'h123);   // repeat with nothing unique behind it
        send_word(12'h800);
        send_word(12'h001);
        send_word(12'h7FF);
        send_word(12'h800);   // the scan stops at the next entry, 001
        send_word(12'h001);   // and then at 7FF
        send_word(12'h7FF);   // none remain
        sent = 17;

        // Random part. Past the depth of the history every word is refused,
        // which checks the overflow report against the frozen state.
        while (sent < WORD_TOTAL)
        begin
            if (sent < 200)
                mode = 0;
            else
                mode = ((sent - 200) / 150 + 1) % 4;
            send_word(pick_value());
            sent++;
        end
        in_valid <= 1'b0;

        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d words, %0d refused with the history full, %0d history scans.",
                 sent, tracker.refused, tracker.scans);
        $display("Idle and stall phases on both sides, with one long receiver hold-off.");
        if (tracker.failures == 0 && tracker.awaited.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, clearing pass included.
    initial
    begin
        #4ms;
        $display("Timeout: the run did not finish in time.");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fuis_pkg.sv
rtl/core/fuis_ram.sv
rtl/core/fuis_core.sv
rtl/core/first_unique_in_stream.sv
rtl/core/fuis_checker.sv
bench/first_unique_in_stream_test.sv
